[design/vtpd_pkg.sv]
// ----------------------------------------------------------------------------
// Vertex transform package
// Shared types, reset constants, the leading-one finder and the single-precision rounding helper.
// ----------------------------------------------------------------------------
package vtpd_pkg;

  typedef logic [31:0] f32_t;

  localparam f32_t CANON_NAN = 32'h7FC0_0000;
  localparam f32_t FP_ONE    = 32'h3F80_0000;

  localparam int NUM_MAT_REGS = 8;
  localparam int CFG_IDX_W    = 4;
  localparam int PIPE_DEPTH   = 24;
  // Stage at which the normal result leaves its adders.
  localparam int NRM_DONE_STAGE = 6;

  // Identity matrix, two elements to a register.
  localparam logic [63:0] MAT_RESET [NUM_MAT_REGS] = '{
    {32'd0, FP_ONE}, 64'd0,
    {FP_ONE, 32'd0}, 64'd0,
    64'd0, {32'd0, FP_ONE},
    64'd0, {FP_ONE, 32'd0}
  };

  // Position of the highest set bit.
  function automatic logic [5:0] lead_pos48(input logic [47:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  // Rounds a normalised significand (leading one at bit 26, sticky in bit 0)
  // to nearest even, including gradual underflow and overflow to infinity.
  // The significand must not be zero.
  function automatic f32_t round_pack(input logic sign, input logic signed [10:0] ex,
                                      input logic [26:0] sig);
    logic [26:0]       s;
    logic [26:0]       mask;
    logic [5:0]        sh;
    logic signed [10:0] e2;
    logic              den;
    logic              inc;
    logic [24:0]       m;
    logic [8:0]        ef;
    logic [22:0]       fr;
    f32_t              r;
    den = (ex < 11'sd1);
    e2  = 11'sd1 - ex;
    if (den) begin
      sh = (e2 > 11'sd27) ? 6'd27 : e2[5:0];
    end else begin
      sh = 6'd0;
    end
    mask = (27'd1 << sh) - 27'd1;
    s    = sig >> sh;
    s[0] = s[0] | (|(sig & mask));
    inc  = s[2] & (s[1] | s[0] | s[3]);
    m    = {1'b0, s[26:3]} + 25'(inc);
    if (den) begin
      ef = m[23] ? 9'd1 : 9'd0;
      fr = m[22:0];
    end else if (m[24]) begin
      ef = 9'(ex) + 9'd1;
      fr = m[23:1];
    end else begin
      ef = 9'(ex);
      fr = m[22:0];
    end
    if (ef >= 9'd255) begin
      r = {sign, 8'hFF, 23'd0};
    end else begin
      r = {sign, ef[7:0], fr};
    end
    return r;
  endfunction

endpackage

[design/vertex_transform_perspective_divide.sv]
// ----------------------------------------------------------------------------
// Vertex transform with perspective divide
// Throughput: one vertex per cycle; the whole pipeline holds while a result waits.
// Depth is set by the 28-bit restoring divider at two quotient bits a stage.
// Reset: pipeline emptied and the matrix set to identity, asynchronously.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_divide (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [vtpd_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        culled_i,
  input  logic        normal_enable_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] nrm_x_i,
  input  logic [31:0] nrm_y_i,
  input  logic [31:0] nrm_z_i,
  input  logic        last_vertex_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_pos_x_o,
  output logic [31:0] out_pos_y_o,
  output logic [31:0] out_pos_z_o,
  output logic [31:0] out_nrm_x_o,
  output logic [31:0] out_nrm_y_o,
  output logic [31:0] out_nrm_z_o,
  output logic        out_last_o
);
  import vtpd_pkg::*;

  localparam int NRM_DLY = PIPE_DEPTH - NRM_DONE_STAGE;

  typedef struct packed {
    logic       culled;
    logic       nen;
    logic       last;
    f32_t [2:0] pos;
    f32_t [2:0] nrm;
  } side_t;

  logic [63:0] mat_q [NUM_MAT_REGS];
  logic        vld_q [PIPE_DEPTH];
  side_t       sb_q  [PIPE_DEPTH];
  f32_t [2:0]  nrm_dly_q [NRM_DLY];
  logic        en;

  f32_t mel    [4][4];
  f32_t pos_in [3];
  f32_t nrm_in [3];
  f32_t pprod  [3][4];
  f32_t nprod  [3][3];
  f32_t p2d1_q [4], p2d2_q [4];
  f32_t n2d1_q [3], n2d2_q [3];
  f32_t s1p [4], s2p [4], s3p [4];
  f32_t s1n [3], s2n [3];
  f32_t quo [3];

  // The pipeline advances unless a finished result is being held.
  assign en         = !vld_q[PIPE_DEPTH-1] || out_ready_i;
  assign in_ready_o = en;

  assign pos_in[0] = pos_x_i;
  assign pos_in[1] = pos_y_i;
  assign pos_in[2] = pos_z_i;
  assign nrm_in[0] = nrm_x_i;
  assign nrm_in[1] = nrm_y_i;
  assign nrm_in[2] = nrm_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MAT_REGS; i++) begin
        mat_q[i] <= MAT_RESET[i];
      end
    end else if (cfg_we_i && (cfg_addr_i < CFG_IDX_W'(NUM_MAT_REGS))) begin
      mat_q[cfg_addr_i[2:0]] <= cfg_wdata_i;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_mr
    for (genvar c = 0; c < 4; c++) begin : g_mc
      if (c % 2 == 1) begin : g_hi
        assign mel[r][c] = mat_q[r*2 + c/2][63:32];
      end else begin : g_lo
        assign mel[r][c] = mat_q[r*2 + c/2][31:0];
      end
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_mulr
    for (genvar c = 0; c < 4; c++) begin : g_pmul
      vtpd_fmul u_pmul (.clk_i, .en_i(en), .a_i(pos_in[r]), .b_i(mel[r][c]), .y_o(pprod[r][c]));
    end
    for (genvar c = 0; c < 3; c++) begin : g_nmul
      vtpd_fmul u_nmul (.clk_i, .en_i(en), .a_i(nrm_in[r]), .b_i(mel[r][c]), .y_o(nprod[r][c]));
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_pcol
    vtpd_fadd u_padd1 (.clk_i, .en_i(en), .a_i(pprod[0][c]), .b_i(pprod[1][c]), .y_o(s1p[c]));
    vtpd_fadd u_padd2 (.clk_i, .en_i(en), .a_i(s1p[c]), .b_i(p2d2_q[c]), .y_o(s2p[c]));
    vtpd_fadd u_padd3 (.clk_i, .en_i(en), .a_i(s2p[c]), .b_i(mel[3][c]), .y_o(s3p[c]));
  end

  for (genvar c = 0; c < 3; c++) begin : g_ncol
    vtpd_fadd u_nadd1 (.clk_i, .en_i(en), .a_i(nprod[0][c]), .b_i(nprod[1][c]), .y_o(s1n[c]));
    vtpd_fadd u_nadd2 (.clk_i, .en_i(en), .a_i(s1n[c]), .b_i(n2d2_q[c]), .y_o(s2n[c]));
    vtpd_fdiv u_div (.clk_i, .en_i(en), .a_i(s3p[c]), .b_i(s3p[3]), .y_o(quo[c]));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        p2d1_q[c] <= pprod[2][c];
        p2d2_q[c] <= p2d1_q[c];
      end
      for (int c = 0; c < 3; c++) begin
        n2d1_q[c] <= nprod[2][c];
        n2d2_q[c] <= n2d1_q[c];
      end
      sb_q[0] <= '{culled: culled_i, nen: normal_enable_i, last: last_vertex_i,
                   pos: {pos_z_i, pos_y_i, pos_x_i}, nrm: {nrm_z_i, nrm_y_i, nrm_x_i}};
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
      nrm_dly_q[0] <= {s2n[2], s2n[1], s2n[0]};
      for (int k = 1; k < NRM_DLY; k++) begin
        nrm_dly_q[k] <= nrm_dly_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_comb begin
    out_valid_o = vld_q[PIPE_DEPTH-1];
    out_last_o  = sb_q[PIPE_DEPTH-1].last;
    if (sb_q[PIPE_DEPTH-1].culled) begin
      out_pos_x_o = sb_q[PIPE_DEPTH-1].pos[0];
      out_pos_y_o = sb_q[PIPE_DEPTH-1].pos[1];
      out_pos_z_o = sb_q[PIPE_DEPTH-1].pos[2];
    end else begin
      out_pos_x_o = quo[0];
      out_pos_y_o = quo[1];
      out_pos_z_o = quo[2];
    end
    if (sb_q[PIPE_DEPTH-1].culled || !sb_q[PIPE_DEPTH-1].nen) begin
      out_nrm_x_o = sb_q[PIPE_DEPTH-1].nrm[0];
      out_nrm_y_o = sb_q[PIPE_DEPTH-1].nrm[1];
      out_nrm_z_o = sb_q[PIPE_DEPTH-1].nrm[2];
    end else begin
      out_nrm_x_o = nrm_dly_q[NRM_DLY-1][0];
      out_nrm_y_o = nrm_dly_q[NRM_DLY-1][1];
      out_nrm_z_o = nrm_dly_q[NRM_DLY-1][2];
    end
  end

endmodule

[design/vtpd_fmul.sv]
// ----------------------------------------------------------------------------
// Single-precision multiplier
// Two register stages: significand product, then normalise and round.
// ----------------------------------------------------------------------------
module vtpd_fmul (
  input  logic           clk_i,
  input  logic           en_i,
  input  vtpd_pkg::f32_t a_i,
  input  vtpd_pkg::f32_t b_i,
  output vtpd_pkg::f32_t y_o
);
  import vtpd_pkg::*;

  typedef struct packed {
    logic               spec;
    f32_t               sval;
    logic               sign;
    logic signed [10:0] ex;
    logic [47:0]        man;
  } mraw_t;

  mraw_t raw_d, raw_q;
  f32_t  y_d, y_q;

  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic [5:0]  lp;
  logic [47:0] norm;
  logic signed [10:0] ex2;

  always_comb begin
    ea     = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb     = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma     = {|a_i[30:23], a_i[22:0]};
    mb     = {|b_i[30:23], b_i[22:0]};
    nan_a  = (&a_i[30:23]) && (|a_i[22:0]);
    nan_b  = (&b_i[30:23]) && (|b_i[22:0]);
    inf_a  = (&a_i[30:23]) && !(|a_i[22:0]);
    inf_b  = (&b_i[30:23]) && !(|b_i[22:0]);
    zero_a = !(|a_i[30:0]);
    zero_b = !(|b_i[30:0]);
    raw_d.sign = a_i[31] ^ b_i[31];
    raw_d.ex   = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd127;
    raw_d.man  = ma * mb;
    raw_d.spec = 1'b1;
    if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
      raw_d.sval = CANON_NAN;
    end else if (inf_a || inf_b) begin
      raw_d.sval = {raw_d.sign, 8'hFF, 23'd0};
    end else if (zero_a || zero_b) begin
      raw_d.sval = {raw_d.sign, 31'd0};
    end else begin
      raw_d.spec = 1'b0;
      raw_d.sval = CANON_NAN;
    end
  end

  always_comb begin
    lp   = lead_pos48(raw_q.man);
    norm = raw_q.man << (6'd47 - lp);
    ex2  = raw_q.ex + $signed({5'd0, lp}) - 11'sd46;
    if (raw_q.spec) begin
      y_d = raw_q.sval;
    end else begin
      y_d = round_pack(raw_q.sign, ex2, {norm[47:22], |norm[21:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_q <= raw_d;
      y_q   <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

[design/vtpd_fadd.sv]
// ----------------------------------------------------------------------------
// Single-precision adder
// Two register stages: align and add, then normalise and round.
// ----------------------------------------------------------------------------
module vtpd_fadd (
  input  logic           clk_i,
  input  logic           en_i,
  input  vtpd_pkg::f32_t a_i,
  input  vtpd_pkg::f32_t b_i,
  output vtpd_pkg::f32_t y_o
);
  import vtpd_pkg::*;

  typedef struct packed {
    logic               spec;
    f32_t               sval;
    logic               sign;
    logic               zsign;
    logic signed [10:0] ex;
    logic [27:0]        sum;
  } araw_t;

  araw_t raw_d, raw_q;
  f32_t  y_d, y_q;

  logic        nan_a, nan_b, inf_a, inf_b;
  f32_t        xb, yb;
  logic [7:0]  ex_x, ex_y, dexp;
  logic [26:0] mx, my, ys, mask;
  logic [4:0]  sh;
  logic [5:0]  lp, lsh;
  logic [26:0] sig;
  logic signed [10:0] ex2;

  always_comb begin
    nan_a = (&a_i[30:23]) && (|a_i[22:0]);
    nan_b = (&b_i[30:23]) && (|b_i[22:0]);
    inf_a = (&a_i[30:23]) && !(|a_i[22:0]);
    inf_b = (&b_i[30:23]) && !(|b_i[22:0]);
    // Larger magnitude goes first so that the difference stays positive.
    if (b_i[30:0] > a_i[30:0]) begin
      xb = b_i;
      yb = a_i;
    end else begin
      xb = a_i;
      yb = b_i;
    end
    ex_x = (xb[30:23] == 8'd0) ? 8'd1 : xb[30:23];
    ex_y = (yb[30:23] == 8'd0) ? 8'd1 : yb[30:23];
    mx   = {|xb[30:23], xb[22:0], 3'b000};
    my   = {|yb[30:23], yb[22:0], 3'b000};
    dexp = ex_x - ex_y;
    sh   = (dexp > 8'd27) ? 5'd27 : dexp[4:0];
    mask = (27'd1 << sh) - 27'd1;
    ys   = my >> sh;
    ys[0] = ys[0] | (|(my & mask));
    raw_d.sign  = xb[31];
    raw_d.zsign = a_i[31] & b_i[31];
    raw_d.ex    = $signed({3'd0, ex_x});
    raw_d.sum   = (xb[31] == yb[31]) ? ({1'b0, mx} + {1'b0, ys}) : ({1'b0, mx} - {1'b0, ys});
    raw_d.spec  = 1'b1;
    if (nan_a || nan_b || (inf_a && inf_b && (a_i[31] != b_i[31]))) begin
      raw_d.sval = CANON_NAN;
    end else if (inf_a) begin
      raw_d.sval = a_i;
    end else if (inf_b) begin
      raw_d.sval = b_i;
    end else begin
      raw_d.spec = 1'b0;
      raw_d.sval = CANON_NAN;
    end
  end

  always_comb begin
    lp  = lead_pos48({20'd0, raw_q.sum});
    lsh = 6'd26 - lp;
    ex2 = raw_q.ex + $signed({5'd0, lp}) - 11'sd26;
    if (lp == 6'd27) begin
      sig = {raw_q.sum[27:2], raw_q.sum[1] | raw_q.sum[0]};
    end else begin
      sig = raw_q.sum[26:0] << lsh;
    end
    if (raw_q.spec) begin
      y_d = raw_q.sval;
    end else if (raw_q.sum == 28'd0) begin
      y_d = {raw_q.zsign, 31'd0};
    end else begin
      y_d = round_pack(raw_q.sign, ex2, sig);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_q <= raw_d;
      y_q   <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

[design/vtpd_fdiv.sv]
// ----------------------------------------------------------------------------
// Single-precision divider
// Unpack stage, fourteen restoring stages of two quotient bits, round stage.
// ----------------------------------------------------------------------------
module vtpd_fdiv (
  input  logic           clk_i,
  input  logic           en_i,
  input  vtpd_pkg::f32_t a_i,
  input  vtpd_pkg::f32_t b_i,
  output vtpd_pkg::f32_t y_o
);
  import vtpd_pkg::*;

  localparam int QBITS      = 28;
  localparam int BITS_STAGE = 2;
  localparam int NSTAGES    = QBITS / BITS_STAGE;

  typedef struct packed {
    logic               spec;
    f32_t               sval;
    logic               sign;
    logic signed [10:0] ex;
    logic [24:0]        rem;
    logic [23:0]        dv;
    logic [QBITS-1:0]   q;
  } dstage_t;

  dstage_t st_q [NSTAGES+1];
  dstage_t pre_d;
  dstage_t step_d [NSTAGES];
  f32_t    y_d, y_q;

  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sgn;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb, na, nb;
  logic [5:0]  la, lb;
  logic [26:0] sig;
  logic signed [10:0] ex2;
  logic        remnz;

  always_comb begin
    ea     = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb     = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma     = {|a_i[30:23], a_i[22:0]};
    mb     = {|b_i[30:23], b_i[22:0]};
    nan_a  = (&a_i[30:23]) && (|a_i[22:0]);
    nan_b  = (&b_i[30:23]) && (|b_i[22:0]);
    inf_a  = (&a_i[30:23]) && !(|a_i[22:0]);
    inf_b  = (&b_i[30:23]) && !(|b_i[22:0]);
    zero_a = !(|a_i[30:0]);
    zero_b = !(|b_i[30:0]);
    sgn    = a_i[31] ^ b_i[31];
    // Subnormal operands are brought to a leading one first.
    la = lead_pos48({24'd0, ma});
    lb = lead_pos48({24'd0, mb});
    na = ma << (6'd23 - la);
    nb = mb << (6'd23 - lb);
    pre_d.sign = sgn;
    pre_d.ex   = $signed({3'd0, ea}) + $signed({5'd0, la})
               - $signed({3'd0, eb}) - $signed({5'd0, lb}) + 11'sd127;
    pre_d.rem  = {1'b0, na};
    pre_d.dv   = nb;
    pre_d.q    = '0;
    pre_d.spec = 1'b1;
    if (nan_a || nan_b || (inf_a && inf_b) || (zero_a && zero_b)) begin
      pre_d.sval = CANON_NAN;
    end else if (zero_b || inf_a) begin
      pre_d.sval = {sgn, 8'hFF, 23'd0};
    end else if (inf_b || zero_a) begin
      pre_d.sval = {sgn, 31'd0};
    end else begin
      pre_d.spec = 1'b0;
      pre_d.sval = CANON_NAN;
    end
  end

  for (genvar k = 0; k < NSTAGES; k++) begin : g_step
    always_comb begin
      step_d[k] = st_q[k];
      for (int b = 0; b < BITS_STAGE; b++) begin
        step_d[k].q = step_d[k].q << 1;
        if (step_d[k].rem >= {1'b0, step_d[k].dv}) begin
          step_d[k].q[0] = 1'b1;
          step_d[k].rem  = step_d[k].rem - {1'b0, step_d[k].dv};
        end
        step_d[k].rem = step_d[k].rem << 1;
      end
    end
  end

  always_comb begin
    remnz = |st_q[NSTAGES].rem;
    if (st_q[NSTAGES].q[QBITS-1]) begin
      sig = {st_q[NSTAGES].q[27:2], st_q[NSTAGES].q[1] | st_q[NSTAGES].q[0] | remnz};
      ex2 = st_q[NSTAGES].ex;
    end else begin
      sig = {st_q[NSTAGES].q[26:1], st_q[NSTAGES].q[0] | remnz};
      ex2 = st_q[NSTAGES].ex - 11'sd1;
    end
    if (st_q[NSTAGES].spec) begin
      y_d = st_q[NSTAGES].sval;
    end else begin
      y_d = round_pack(st_q[NSTAGES].sign, ex2, sig);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= pre_d;
      for (int k = 0; k < NSTAGES; k++) begin
        st_q[k+1] <= step_d[k];
      end
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

[dv/vertex_transform_perspective_divide_tb.sv]
// ----------------------------------------------------------------------------
// Vertex transform with perspective divide testbench
// Streams vertices through the block under several matrix settings and
// compares every result with a bit-exact single-precision prediction,
// with random idling on both handshakes and one long output hold-off.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_divide_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vtpd_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_COLS01 = 4'd0,
    REG_ROW0_COLS23 = 4'd1,
    REG_ROW1_COLS01 = 4'd2,
    REG_ROW1_COLS23 = 4'd3,
    REG_ROW2_COLS01 = 4'd4,
    REG_ROW2_COLS23 = 4'd5,
    REG_ROW3_COLS01 = 4'd6,
    REG_ROW3_COLS23 = 4'd7,
    REG_UNMAPPED    = 4'd9
  } mat_reg_e;

  localparam f32_t F_POS_INF = 32'h7F80_0000;
  localparam f32_t F_NEG_ZERO = 32'h8000_0000;
  localparam int   WATCHDOG_LIMIT = 5000;
  localparam int   HOLD_OFF_CYCLES = 300;
  localparam int   RANDOM_PER_PHASE = 250;

  typedef struct packed {
    logic culled;
    logic nrm_en;
    logic last;
    f32_t px, py, pz;
    f32_t nx, ny, nz;
  } vertex_t;

  typedef struct packed {
    f32_t px, py, pz;
    f32_t nx, ny, nz;
    logic last;
  } vertex_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        culled_i = 1'b0;
  logic        normal_enable_i = 1'b0;
  logic [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [31:0] nrm_x_i = '0, nrm_y_i = '0, nrm_z_i = '0;
  logic        last_vertex_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] out_pos_x_o, out_pos_y_o, out_pos_z_o;
  logic [31:0] out_nrm_x_o, out_nrm_y_o, out_nrm_z_o;
  logic        out_last_o;

  vertex_transform_perspective_divide dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [63:0] matrix [NUM_MAT_REGS];
  vertex_t     pending_vertices [$];
  vertex_out_t expected_vertices [$];
  int          mismatches = 0;
  bit          idling_on = 1'b1;
  bit          hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;

  // ---------------- single-precision arithmetic via double ----------------
  // A double holds every single exactly, and one double operation rounded
  // again to single gives the correctly rounded single result.

  function automatic real f32_to_real(f32_t b);
    logic [63:0] d;
    int          lead;
    if (b[30:23] == 8'hFF) begin
      d = {b[31], 11'h7FF, (b[22:0] != 0) ? {1'b1, 51'd0} : 52'd0};
    end else if (b[30:23] == 8'd0) begin
      if (b[22:0] == 0) begin
        d = {b[31], 63'd0};
      end else begin
        lead = 0;
        for (int i = 0; i < 23; i++) if (b[i]) lead = i;
        d = {b[31], 11'(lead - 149 + 1023), 52'(64'(b[22:0]) << (52 - lead))};
      end
    end else begin
      d = {b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0};
    end
    return $bitstoreal(d);
  endfunction

  function automatic f32_t real_to_f32(real v);
    logic [63:0] d, sig, kept, rem, half;
    int          e, sh;
    d = $realtobits(v);
    if (d[62:52] == 11'h7FF) begin
      return (d[51:0] != 0) ? CANON_NAN : {d[63], F_POS_INF[30:0]};
    end
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    e   = int'(d[62:52]) - 1023 + 127;
    sig = {11'd0, 1'b1, d[51:0]};
    sh  = (e >= 1) ? 29 : 30 - e;
    if (sh > 60) sh = 60;
    kept = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (e < 1) return {d[63], kept[30:0]};
    if (kept[24]) begin
      kept = kept >> 1;
      e++;
    end
    if (e >= 255) return {d[63], F_POS_INF[30:0]};
    return {d[63], 8'(e), kept[22:0]};
  endfunction

  function automatic f32_t f32_mul(f32_t a, f32_t b);
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  function automatic f32_t f32_add(f32_t a, f32_t b);
    return real_to_f32(f32_to_real(a) + f32_to_real(b));
  endfunction

  function automatic f32_t f32_div(f32_t a, f32_t w);
    bit a_nan;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
    if (w[30:0] == 0) begin
      if (a_nan || a[30:0] == 0) return CANON_NAN;
      return {a[31] ^ w[31], F_POS_INF[30:0]};
    end
    return real_to_f32(f32_to_real(a) / f32_to_real(w));
  endfunction

  function automatic f32_t mat_el(int r, int c);
    logic [63:0] v;
    v = matrix[r * 2 + c / 2];
    return (c % 2) ? v[63:32] : v[31:0];
  endfunction

  function automatic vertex_out_t transform_vertex(vertex_t v);
    vertex_out_t o;
    f32_t        acc [4];
    f32_t        nrm [3];
    f32_t        s;
    o.last = v.last;
    if (v.culled) begin
      {o.px, o.py, o.pz} = {v.px, v.py, v.pz};
      {o.nx, o.ny, o.nz} = {v.nx, v.ny, v.nz};
      return o;
    end
    for (int c = 0; c < 4; c++) begin
      s = f32_add(f32_mul(v.px, mat_el(0, c)), f32_mul(v.py, mat_el(1, c)));
      s = f32_add(s, f32_mul(v.pz, mat_el(2, c)));
      acc[c] = f32_add(s, f32_mul(FP_ONE, mat_el(3, c)));
    end
    o.px = f32_div(acc[0], acc[3]);
    o.py = f32_div(acc[1], acc[3]);
    o.pz = f32_div(acc[2], acc[3]);
    if (v.nrm_en) begin
      for (int c = 0; c < 3; c++) begin
        s = f32_add(f32_mul(v.nx, mat_el(0, c)), f32_mul(v.ny, mat_el(1, c)));
        nrm[c] = f32_add(s, f32_mul(v.nz, mat_el(2, c)));
        if (nrm[c][30:23] == 8'hFF && nrm[c][22:0] != 0) nrm[c] = CANON_NAN;
      end
      {o.nx, o.ny, o.nz} = {nrm[0], nrm[1], nrm[2]};
    end else begin
      {o.nx, o.ny, o.nz} = {v.nx, v.ny, v.nz};
    end
    return o;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic f32_t rand_f32();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return {r[31], 31'd0};
      1: return {r[31], F_POS_INF[30:0]};
      2: return {r[31], 8'hFF, r[22:1], 1'b1};
      3: return {r[31], 8'd0, r[22:0]};
      4: return {r[31], FP_ONE[30:0]};
      5, 6: return r;
      default: return {r[31], 8'(8'd117 + $urandom_range(0, 20)), r[22:0]};
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    v.culled = ($urandom_range(0, 7) == 0);
    v.nrm_en = $urandom_range(0, 1);
    v.last   = ($urandom_range(0, 15) == 0);
    v.px = rand_f32();
    v.py = rand_f32();
    v.pz = rand_f32();
    v.nx = rand_f32();
    v.ny = rand_f32();
    v.nz = rand_f32();
    return v;
  endfunction

  function automatic vertex_t make_vertex(logic culled, logic nrm_en, logic last,
                                          f32_t px, f32_t py, f32_t pz, f32_t n);
    vertex_t v;
    v.culled = culled;
    v.nrm_en = nrm_en;
    v.last   = last;
    {v.px, v.py, v.pz} = {px, py, pz};
    {v.nx, v.ny, v.nz} = {n, ~n, n ^ 32'h4000_0000};
    return v;
  endfunction

  task automatic write_matrix_reg(mat_reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    if (int'(idx) < NUM_MAT_REGS) matrix[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_matrix(logic [63:0] regs [NUM_MAT_REGS]);
    for (int i = 0; i < NUM_MAT_REGS; i++) write_matrix_reg(mat_reg_e'(i), regs[i]);
  endtask

  function automatic logic [63:0] rand_reg_pair();
    return {rand_f32(), rand_f32()};
  endfunction

  task automatic wait_drained();
    while (pending_vertices.size() != 0 || in_valid_i || expected_vertices.size() != 0)
      @(posedge clk_i);
    repeat (PIPE_DEPTH + 6) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    mismatches++;
  endtask

  // ---------------- request driver ----------------
  vertex_t cur_vertex;
  int      send_gap = 0;
  int      idle_cycles = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic next_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (in_valid_i) expected_vertices.push_back(transform_vertex(cur_vertex));
      next_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_vertices.size() != 0) begin
        cur_vertex = pending_vertices.pop_front();
        next_valid = 1'b1;
        send_gap   = idling_on ? $urandom_range(0, 4) : 0;
      end
      in_valid_i      <= next_valid;
      culled_i        <= cur_vertex.culled;
      normal_enable_i <= cur_vertex.nrm_en;
      last_vertex_i   <= cur_vertex.last;
      pos_x_i         <= cur_vertex.px;
      pos_y_i         <= cur_vertex.py;
      pos_z_i         <= cur_vertex.pz;
      nrm_x_i         <= cur_vertex.nx;
      nrm_y_i         <= cur_vertex.ny;
      nrm_z_i         <= cur_vertex.nz;
    end
  end

  // ---------------- result monitor ----------------
  int recv_wait = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_vertices.size() == 0) begin
          report_mismatch("unexpected result", out_pos_x_o, '0);
        end else begin
          want = expected_vertices.pop_front();
          if (out_pos_x_o !== want.px) report_mismatch("out_pos_x", out_pos_x_o, want.px);
          if (out_pos_y_o !== want.py) report_mismatch("out_pos_y", out_pos_y_o, want.py);
          if (out_pos_z_o !== want.pz) report_mismatch("out_pos_z", out_pos_z_o, want.pz);
          if (out_nrm_x_o !== want.nx) report_mismatch("out_nrm_x", out_nrm_x_o, want.nx);
          if (out_nrm_y_o !== want.ny) report_mismatch("out_nrm_y", out_nrm_y_o, want.ny);
          if (out_nrm_z_o !== want.nz) report_mismatch("out_nrm_z", out_nrm_z_o, want.nz);
          if (out_last_o !== want.last) begin
            report_mismatch("out_last", 32'(out_last_o), 32'(want.last));
          end
        end
        recv_wait = idling_on ? $urandom_range(0, 4) : 0;
      end
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        recv_wait     = HOLD_OFF_CYCLES;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("** vertex_transform_perspective_divide: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- test sequence ----------------
  initial begin
    logic [63:0] regs [NUM_MAT_REGS];
    for (int i = 0; i < NUM_MAT_REGS; i++) matrix[i] = MAT_RESET[i];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Identity matrix out of reset: extremes, culling and the normal switch.
    pending_vertices.push_back(make_vertex(1, 1, 1, '1, '1, '1, '1));
    pending_vertices.push_back(make_vertex(1, 0, 0, '0, '0, '0, '0));
    pending_vertices.push_back(make_vertex(0, 0, 0, '0, F_NEG_ZERO, FP_ONE, FP_ONE));
    pending_vertices.push_back(make_vertex(0, 1, 1, '1, 32'h7F7F_FFFF, 32'h0000_0001,
                                           32'h7F7F_FFFF));
    pending_vertices.push_back(make_vertex(0, 1, 0, F_POS_INF, 32'hFF80_0000,
                                           32'h7FC0_0001, 32'h0080_0000));
    pending_vertices.push_back(make_vertex(0, 0, 1, 32'h8000_0001, 32'h007F_FFFF,
                                           32'hFF7F_FFFF, 32'h7FFF_FFFF));
    pending_vertices.push_back(make_vertex(0, 1, 0, 32'h4049_0FDB, 32'hC2F6_E979,
                                           32'h3EAA_AAAB, 32'h3F35_04F3));
    for (int i = 0; i < RANDOM_PER_PHASE; i++) pending_vertices.push_back(rand_vertex());
    wait_drained();

    // Perspective matrix: w is x plus z, so x equal to minus z divides by zero.
    regs = '{64'h0000_0000_4000_0000, 64'h3F80_0000_0000_0000,
             64'h4000_0000_0000_0000, 64'h0000_0000_0000_0000,
             64'h0000_0000_0000_0000, 64'h3F80_0000_3F80_0000,
             64'h0000_0000_0000_0000, 64'h0000_0000_BF80_0000};
    load_matrix(regs);
    write_matrix_reg(REG_UNMAPPED, '1);
    pending_vertices.push_back(make_vertex(0, 1, 0, FP_ONE, FP_ONE, '0, FP_ONE));
    pending_vertices.push_back(make_vertex(0, 1, 0, 32'hBF80_0000, FP_ONE, F_NEG_ZERO,
                                           FP_ONE));
    pending_vertices.push_back(make_vertex(0, 0, 1, '0, '0, '0, '0));
    pending_vertices.push_back(make_vertex(0, 0, 0, 32'h7FC0_0000, '0, '0, '0));
    pending_vertices.push_back(make_vertex(0, 1, 0, F_POS_INF, FP_ONE, '0, '0));
    pending_vertices.push_back(make_vertex(0, 0, 0, FP_ONE, FP_ONE, FP_ONE, FP_ONE));
    pending_vertices.push_back(make_vertex(1, 1, 0, FP_ONE, FP_ONE, '0, FP_ONE));
    for (int i = 0; i < RANDOM_PER_PHASE; i++) pending_vertices.push_back(rand_vertex());
    wait_drained();

    // All-zero matrix: w is zero unless a position is infinite or a NaN.
    regs = '{default: 64'd0};
    load_matrix(regs);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) pending_vertices.push_back(rand_vertex());
    wait_drained();

    // All-ones matrix: every element is a NaN.
    regs = '{default: '1};
    load_matrix(regs);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) pending_vertices.push_back(rand_vertex());
    wait_drained();

    // Random matrices; one phase runs flat out with a long output hold-off
    // so that the pipeline fills and back-pressure reaches the input.
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < NUM_MAT_REGS; i++) regs[i] = rand_reg_pair();
      load_matrix(regs);
      idling_on = (ph != 1);
      if (ph == 1) hold_off_req = 1'b1;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) pending_vertices.push_back(rand_vertex());
      wait_drained();
      idling_on = 1'b1;
    end

    if (expected_vertices.size() != 0) begin
      $display("%0d results never arrived", expected_vertices.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("** vertex_transform_perspective_divide: PASSED **");
    end else begin
      $display("** vertex_transform_perspective_divide: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
design/vtpd_pkg.sv
design/vtpd_fmul.sv
design/vtpd_fadd.sv
design/vtpd_fdiv.sv
design/vertex_transform_perspective_divide.sv
dv/vertex_transform_perspective_divide_tb.sv
